### hw/rtl/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg: shared types and constants of the spectrum bar binning unit
// Register indexes, field widths and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package sbb_pkg;

   localparam int MAX_BARS = 64;
   localparam int MAX_BINS = 4096;

   localparam int BIN_W    = 13;
   localparam int SLOT_W   = 6;
   localparam int CNT_W    = 7;
   localparam int DIV_W    = 7;
   localparam int HGT_W    = 10;
   localparam int FS_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_FIRST_BIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BAR_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NORM_DIVISOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHART_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE   = 3'd4;

   // request payload: table load or one transform bin
   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] bar_slot;
      logic [BIN_W-1:0]  bar_end_bin;
      logic [31:0]       real_part;
      logic [31:0]       imag_part;
      logic              last_bin;
   } sbb_req_type;

   // response payload: one finished bar
   typedef struct packed {
      logic [SLOT_W-1:0] bar_number;
      logic [HGT_W-1:0]  bar_height;
      logic              bar_empty;
      logic              last_bar;
   } sbb_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_bin;     // latch bin payload, start power product
      logic accum;        // add product into the sum
      logic calc_bar;     // start sqrt/divide of current bar
      logic step;         // one iteration of sqrt or divide
      logic sel_div;      // 0: sqrt phase, 1: divide phase
      logic finish;       // load result register, advance bar
      logic clear_frame;  // return to frame start
      logic bump_counter; // advance bin counter
   } sbb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic bin_ok;       // bin index in range and at/after first_bin
      logic bar_left;     // a bar is still open
      logic bar_closes;   // current bar end at or below bin index
   } sbb_status_type;

endpackage

### hw/rtl/sbb_if.sv
// ----------------------------------------------------------------------------
// sbb_if: valid/ready channel
// Generic handshake channel carrying one payload of type payload_type.
// ----------------------------------------------------------------------------
interface sbb_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/sbb_ctrl.sv
// ----------------------------------------------------------------------------
// sbb_ctrl: sequencer of the bar binning unit
// Accepts one item at a time, steps the datapath through power accumulation,
// bar closing (square root then divide) and the end-of-frame flush.
// ----------------------------------------------------------------------------
module sbb_ctrl
   import sbb_pkg::*;
#(
   parameter int ROOT_STEPS = 32,
   parameter int DIV_STEPS  = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  logic           in_kind,
   input  logic           in_last,
   output logic           in_ready,
   output logic           out_valid,
   input  logic           out_ready,
   input  sbb_status_type status,
   output sbb_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_ACCUM, ST_ROOT, ST_DIV, ST_SHOW, ST_FLUSH
   } state_type;

   localparam int STEP_W = $clog2(ROOT_STEPS > DIV_STEPS ? ROOT_STEPS : DIV_STEPS) + 1;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_ff, last_in;
   logic              flushing_ff, flushing_in;
   logic              out_valid_ff, out_valid_in;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      flushing_in  = flushing_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid && in_kind) begin
               cmd.load_bin = 1'b1;
               last_in      = in_last;
               flushing_in  = 1'b0;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // close bars whose end lies at or below this bin, then add it
            if (status.bin_ok && status.bar_left && status.bar_closes) begin
               cmd.calc_bar = 1'b1;
               step_in      = '0;
               state_in     = ST_ROOT;
            end else if (status.bin_ok && status.bar_left) begin
               state_in = ST_ACCUM;
            end else begin
               flushing_in = 1'b1;
               state_in    = ST_FLUSH;
            end
         end
         ST_ACCUM: begin
            cmd.accum   = 1'b1;
            flushing_in = 1'b1;
            state_in    = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (last_ff && status.bar_left) begin
               cmd.calc_bar = 1'b1;
               step_in      = '0;
               state_in     = ST_ROOT;
            end else begin
               if (last_ff) cmd.clear_frame = 1'b1;
               else cmd.bump_counter = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step    = 1'b1;
            cmd.sel_div = 1'b1;
            step_in     = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_SHOW;
            end
         end
         ST_SHOW: begin
            if (!out_valid_ff) begin
               cmd.finish   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = flushing_ff ? ST_FLUSH : ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (out_valid_ff && out_ready) out_valid_in = 1'b0;
      if (cmd.finish) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         last_ff      <= 1'b0;
         flushing_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
         flushing_ff  <= flushing_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### hw/rtl/sbb_datapath.sv
// ----------------------------------------------------------------------------
// sbb_datapath: arithmetic and state of the bar binning unit
// Bar end table, bin counter, saturating power sum, bit-serial square root
// and restoring divider that produce the bar height.
// ----------------------------------------------------------------------------
module sbb_datapath
   import sbb_pkg::*;
#(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tbl_we,
   input  logic [SLOT_W-1:0]    tbl_slot,
   input  logic [BIN_W-1:0]     tbl_end,
   input  logic [31:0]          real_part,
   input  logic [31:0]          imag_part,
   input  logic [BIN_W-1:0]     first_bin,
   input  logic [CNT_W-1:0]     bar_count,
   input  logic [DIV_W-1:0]     norm_divisor,
   input  logic [HGT_W-1:0]     chart_height,
   input  logic [FS_W-1:0]      full_scale,
   input  sbb_cmd_type          cmd,
   output sbb_status_type       status,
   output logic [SLOT_W-1:0]    bar_number,
   output logic [HGT_W-1:0]     bar_height,
   output logic                 bar_empty,
   output logic                 last_bar
);

   localparam int BAR_W = $clog2(MAX_BARS) + 1;
   localparam int IDX_W = $clog2(MAX_BARS);
   localparam int MAG_W = SAMPLE_BITS;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int DEN_W = FS_W + DIV_W;
   localparam int NUM_W = 32 + HGT_W;

   logic [BIN_W-1:0] end_table [MAX_BARS];
   logic [BIN_W-1:0] bar_end_ff;

   logic [BIN_W-1:0] bin_ff, bin_in;
   logic [BAR_W-1:0] bar_ff, bar_in;
   logic [63:0]      sum_ff, sum_in;
   logic             has_ff, has_in;
   logic [MAG_W-1:0] re_ff, im_ff;
   logic [SQ_W-1:0]  re_sq_ff, im_sq_ff;
   logic [63:0]      rem_ff, rem_in;
   logic [63:0]      root_ff, root_in;
   logic [63:0]      bit_ff, bit_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   drem_ff, drem_in;
   logic [DEN_W-1:0] den_ff;
   logic [SLOT_W-1:0] num_ff;
   logic [HGT_W-1:0] hgt_ff;
   logic             empty_ff, lastb_ff;

   logic [BAR_W-1:0] nb;
   logic [MAG_W-1:0] re_raw, im_raw;
   logic [64:0]      add_wide;
   logic [63:0]      trial;
   logic [DEN_W:0]   dshift;
   logic [NUM_W-1:0] hcalc;

   assign nb = (bar_count > CNT_W'(MAX_BARS)) ? BAR_W'(MAX_BARS) : BAR_W'(bar_count);
   assign re_raw = real_part[MAG_W-1:0];
   assign im_raw = imag_part[MAG_W-1:0];

   assign status.bin_ok     = (bin_ff >= first_bin) && (bin_ff < BIN_W'(MAX_BINS));
   assign status.bar_left   = (bar_ff < nb);
   assign status.bar_closes = (bin_ff >= bar_end_ff);

   always_ff @(posedge clock) begin
      if (tbl_we && (32'(tbl_slot) < MAX_BARS)) end_table[tbl_slot[IDX_W-1:0]] <= tbl_end;
      bar_end_ff <= end_table[bar_in[IDX_W-1:0]];
   end

   assign add_wide = {1'b0, sum_ff} + 65'(re_sq_ff) + 65'(im_sq_ff);
   assign trial    = root_ff + bit_ff;
   assign dshift   = {drem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   assign hcalc    = (quo_ff > NUM_W'(chart_height)) ? NUM_W'(chart_height) : quo_ff;

   always_comb begin
      bin_in  = bin_ff;
      bar_in  = bar_ff;
      sum_in  = sum_ff;
      has_in  = has_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      quo_in  = quo_ff;
      drem_in = drem_ff;
      if (cmd.accum) begin
         sum_in = add_wide[64] ? '1 : add_wide[63:0];
         has_in = 1'b1;
      end
      if (cmd.calc_bar) begin
         rem_in  = sum_ff;
         root_in = '0;
         bit_in  = 64'd1 << 62;
      end
      if (cmd.step && !cmd.sel_div) begin
         // one bit of the root per step
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            quo_in  = NUM_W'(root_in[31:0]) * NUM_W'(chart_height);
            drem_in = '0;
         end
      end
      if (cmd.step && cmd.sel_div) begin
         // restoring divide, NUM_W bits over the DIV phase steps
         if (dshift >= {1'b0, den_ff}) begin
            drem_in = dshift - {1'b0, den_ff};
            quo_in  = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            drem_in = dshift;
            quo_in  = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         bar_in = bar_ff + 1'b1;
         sum_in = '0;
         has_in = 1'b0;
      end
      if (cmd.bump_counter && bin_ff < BIN_W'(MAX_BINS)) bin_in = bin_ff + 1'b1;
      if (cmd.clear_frame) begin
         bin_in = BIN_W'(1);
         bar_in = '0;
         sum_in = '0;
         has_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff <= BIN_W'(1);
         bar_ff <= '0;
         sum_ff <= '0;
         has_ff <= 1'b0;
      end else begin
         bin_ff <= bin_in;
         bar_ff <= bar_in;
         sum_ff <= sum_in;
         has_ff <= has_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      quo_ff  <= quo_in;
      drem_ff <= drem_in;
      if (cmd.load_bin) begin
         re_ff <= re_raw[MAG_W-1] ? MAG_W'(0) - re_raw : re_raw;
         im_ff <= im_raw[MAG_W-1] ? MAG_W'(0) - im_raw : im_raw;
      end
      re_sq_ff <= SQ_W'(re_ff) * SQ_W'(re_ff);
      im_sq_ff <= SQ_W'(im_ff) * SQ_W'(im_ff);
      if (cmd.calc_bar) begin
         den_ff <= DEN_W'((full_scale == '0 ? FS_W'(1) : full_scale))
                 * DEN_W'((norm_divisor == '0 ? DIV_W'(1) : norm_divisor));
      end
      if (cmd.finish) begin
         num_ff   <= bar_ff[SLOT_W-1:0];
         hgt_ff   <= has_ff ? hcalc[HGT_W-1:0] : '0;
         empty_ff <= !has_ff;
         lastb_ff <= (bar_ff + 1'b1 == nb);
      end
   end

   assign bar_number = num_ff;
   assign bar_height = hgt_ff;
   assign bar_empty  = empty_ff;
   assign last_bar   = lastb_ff;

endmodule

### hw/rtl/spectrum_bar_binning_unit.sv
// ----------------------------------------------------------------------------
// spectrum_bar_binning_unit: FFT bins to spectrum bar heights
// Table loads are written while idle; a bin is latched, checked and, in
// range, accumulated; each bar it closes or flushes runs a bit-serial square
// root, then a restoring divide. One item at a time; a finished bar waits
// only while the previous one is still held in the result register.
// Reset (synchronous, active high) restores CSRs, control and frame state; the
// bar end table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module spectrum_bar_binning_unit
   import sbb_pkg::*;
#(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   sbb_if.sink                  req,
   sbb_if.source                rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int NUM_W = 32 + HGT_W;

   logic [BIN_W-1:0]  first_bin_ff;
   logic [CNT_W-1:0]  bar_count_ff;
   logic [DIV_W-1:0]  norm_divisor_ff;
   logic [HGT_W-1:0]  chart_height_ff;
   logic [FS_W-1:0]   full_scale_ff;
   sbb_cmd_type       cmd;
   sbb_status_type    status;
   logic              in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_bin_ff    <= BIN_W'(1);
         bar_count_ff    <= CNT_W'(60);
         norm_divisor_ff <= DIV_W'(5);
         chart_height_ff <= HGT_W'(40);
         full_scale_ff   <= FS_W'(32);
      end else if (csr_we) begin
         case (csr_index)
            REG_FIRST_BIN:    first_bin_ff    <= csr_data[BIN_W-1:0];
            REG_BAR_COUNT:    bar_count_ff    <= csr_data[CNT_W-1:0];
            REG_NORM_DIVISOR: norm_divisor_ff <= csr_data[DIV_W-1:0];
            REG_CHART_HEIGHT: chart_height_ff <= csr_data[HGT_W-1:0];
            REG_FULL_SCALE:   full_scale_ff   <= csr_data[FS_W-1:0];
            default: ;
         endcase
      end
   end

   assign req.ready = in_ready;

   sbb_ctrl #(
      .ROOT_STEPS(32),
      .DIV_STEPS (NUM_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_kind  (req.data.kind),
      .in_last  (req.data.last_bin),
      .in_ready (in_ready),
      .out_valid(rsp.valid),
      .out_ready(rsp.ready),
      .status   (status),
      .cmd      (cmd)
   );

   sbb_datapath #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .tbl_we      (req.valid && in_ready && !req.data.kind),
      .tbl_slot    (req.data.bar_slot),
      .tbl_end     (req.data.bar_end_bin),
      .real_part   (req.data.real_part),
      .imag_part   (req.data.imag_part),
      .first_bin   (first_bin_ff),
      .bar_count   (bar_count_ff),
      .norm_divisor(norm_divisor_ff),
      .chart_height(chart_height_ff),
      .full_scale  (full_scale_ff),
      .cmd         (cmd),
      .status      (status),
      .bar_number  (rsp.data.bar_number),
      .bar_height  (rsp.data.bar_height),
      .bar_empty   (rsp.data.bar_empty),
      .last_bar    (rsp.data.last_bar)
   );

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the spectrum bar binning unit
// Loads bar end tables, streams bins through the request channel and checks
// every bar height transfer against a cycle-free predictor of the binning.
// ----------------------------------------------------------------------------
module tb;
   import sbb_pkg::*;

   localparam int NUM_BARS = 64;
   localparam int NUM_BINS = 4096;
   localparam int RANDOM_ITEMS = 100;
   localparam int SETTLE_CYCLES = 120;

   localparam logic KIND_TABLE = 1'b0;
   localparam logic KIND_BIN   = 1'b1;

   class bar_scoreboard;
      sbb_rsp_type       bars_due[$];
      logic [BIN_W-1:0]  end_table[NUM_BARS];
      int unsigned       bin_idx;
      int unsigned       bar_idx;
      longint unsigned   power_acc;
      bit                has_bins;
      int unsigned       first_bin, bar_count, norm_div, chart_h, full_scale;
      int                errors;

      function new();
         foreach (end_table[i]) end_table[i] = '0;
         bin_idx = 1; bar_idx = 0; power_acc = 0; has_bins = 0;
         first_bin = 1; bar_count = 60; norm_div = 5; chart_h = 40; full_scale = 32;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
         case (idx)
            REG_FIRST_BIN:    first_bin  = val[BIN_W-1:0];
            REG_BAR_COUNT:    bar_count  = val[CNT_W-1:0];
            REG_NORM_DIVISOR: norm_div   = val[DIV_W-1:0];
            REG_CHART_HEIGHT: chart_h    = val[HGT_W-1:0];
            REG_FULL_SCALE:   full_scale = val[FS_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned int_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function longint unsigned abs_sample(logic [31:0] raw);
         if (raw[31]) return (64'd1 << 32) - {32'd0, raw};
         return {32'd0, raw};
      endfunction

      function int unsigned bars_used();
         return (bar_count > NUM_BARS) ? NUM_BARS : bar_count;
      endfunction

      function void close_bar();
         longint unsigned h, d1, d2;
         sbb_rsp_type b;
         h = 0;
         if (has_bins) begin
            d1 = (full_scale != 0) ? full_scale : 1;
            d2 = (norm_div != 0) ? norm_div : 1;
            h = int_root(power_acc) * chart_h / (d1 * d2);
            if (h > chart_h) h = chart_h;
         end
         b.bar_number = bar_idx[SLOT_W-1:0];
         b.bar_height = h[HGT_W-1:0];
         b.bar_empty  = !has_bins;
         b.last_bar   = (bar_idx + 1 == bars_used());
         bars_due.push_back(b);
         bar_idx++;
         power_acc = 0;
         has_bins = 0;
      endfunction

      function void note_request(sbb_req_type r);
         longint unsigned re, im, p;
         int unsigned nb;
         nb = bars_used();
         if (r.kind == KIND_TABLE) begin
            end_table[r.bar_slot] = r.bar_end_bin;
            return;
         end
         if (bin_idx >= first_bin && bin_idx < NUM_BINS) begin
            while (bar_idx < nb && bin_idx >= end_table[bar_idx]) close_bar();
            if (bar_idx < nb) begin
               re = abs_sample(r.real_part);
               im = abs_sample(r.imag_part);
               p = re * re + im * im;
               power_acc = (power_acc > 64'hFFFF_FFFF_FFFF_FFFF - p) ?
                           64'hFFFF_FFFF_FFFF_FFFF : power_acc + p;
               has_bins = 1;
            end
         end
         if (r.last_bin) begin
            while (bar_idx < nb) close_bar();
            bin_idx = 1; bar_idx = 0; power_acc = 0; has_bins = 0;
         end else if (bin_idx < NUM_BINS) begin
            bin_idx++;
         end
      endfunction

      function void check_bar(sbb_rsp_type r);
         sbb_rsp_type e;
         if (bars_due.size() == 0) begin
            $error("unexpected bar transfer: bar_number %0d", r.bar_number);
            errors++;
            return;
         end
         e = bars_due.pop_front();
         if (r.bar_number !== e.bar_number) begin
            $error("bar_number expected %0d actual %0d", e.bar_number, r.bar_number);
            errors++;
         end
         if (r.bar_height !== e.bar_height) begin
            $error("bar_height expected %0d actual %0d", e.bar_height, r.bar_height);
            errors++;
         end
         if (r.bar_empty !== e.bar_empty) begin
            $error("bar_empty expected %0d actual %0d", e.bar_empty, r.bar_empty);
            errors++;
         end
         if (r.last_bar !== e.last_bar) begin
            $error("last_bar expected %0d actual %0d", e.last_bar, r.last_bar);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   sbb_if #(.payload_type(sbb_req_type)) req_ch ();
   sbb_if #(.payload_type(sbb_rsp_type)) rsp_ch ();

   spectrum_bar_binning_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   bar_scoreboard sb = new();
   bit            quiet;
   int unsigned   bars_in_frame;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #200_000_000;
      $display("status: fail");
      $finish;
   end

   // result side: random stalls after each transfer, none while quiet
   initial begin : bar_sink
      int unsigned stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_bar(rsp_ch.data);
            stall = quiet ? 0 : $urandom_range(0, 4);
         end
         if (reset || stall > 0) begin
            rsp_ch.ready <= 1'b0;
            if (!reset) stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send(sbb_req_type it);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(it);
   endtask

   task automatic load_end(int unsigned slot, int unsigned end_bin);
      sbb_req_type it;
      it = '0;
      it.kind        = KIND_TABLE;
      it.bar_slot    = slot[SLOT_W-1:0];
      it.bar_end_bin = end_bin[BIN_W-1:0];
      it.real_part   = $urandom();
      it.imag_part   = $urandom();
      it.last_bin    = 1'($urandom_range(0, 1));
      send(it);
   endtask

   task automatic send_bin(logic [31:0] re, logic [31:0] im, logic last);
      sbb_req_type it;
      it = '0;
      it.kind        = KIND_BIN;
      it.bar_slot    = SLOT_W'($urandom());
      it.bar_end_bin = BIN_W'($urandom());
      it.real_part   = re;
      it.imag_part   = im;
      it.last_bin    = last;
      send(it);
   endtask

   // drop valid, let every pending bar arrive, then let the block settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (sb.bars_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(int unsigned fb, int unsigned bc, int unsigned nd,
                               int unsigned ch, int unsigned fs);
      logic [CSR_DAT_W-1:0] vals[5];
      logic [CSR_IDX_W-1:0] idxs[5];
      idxs = '{REG_FIRST_BIN, REG_BAR_COUNT, REG_NORM_DIVISOR, REG_CHART_HEIGHT,
               REG_FULL_SCALE};
      vals = '{fb[15:0], bc[15:0], nd[15:0], ch[15:0], fs[15:0]};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idxs[i];
         csr_data  <= vals[i];
         @(posedge clock);
         sb.write_reg(idxs[i], vals[i]);
      end
      csr_we <= 1'b0;
      bars_in_frame = sb.bars_used();
   endtask

   function automatic logic [31:0] pick_sample();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom();
         1: v = $urandom_range(0, 3000);
         2: v = $urandom_range(0, 1 << 20);
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h0000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h8000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   initial begin : stimulus
      int unsigned sent, n, e, nb;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      quiet = 1'b0;
      bars_in_frame = 60;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every table entry so no bar end is read unwritten
      for (int i = 0; i < NUM_BARS; i++) load_end(i, 2 * i + 2);

      // default registers: full flush of 60 bars
      send_bin(32'h0, 32'h0, 1'b0);
      send_bin(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_bin(32'd300, -32'd200, 1'b0);
      send_bin(32'd5, 32'd7, 1'b1);
      wait_idle();

      // zero divisors, zero end entry, bins below first_bin, saturating sum
      apply_config(3, 3, 0, 1023, 0);
      load_end(0, 0);
      load_end(1, 6);
      load_end(2, 4096);
      send_bin(32'd9, 32'd9, 1'b0);
      send_bin(32'd9, 32'd9, 1'b0);
      send_bin(32'd1, 32'd0, 1'b0);
      for (int i = 0; i < 4; i++) send_bin(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_bin(32'h1234, 32'hFFFF_0000, 1'b1);
      wait_idle();

      // bar count zero, then beyond the maximum together with first_bin past all bins
      apply_config(1, 0, 1, 1, 1);
      send_bin(32'd50, 32'd50, 1'b0);
      send_bin(32'd50, 32'd50, 1'b1);
      wait_idle();
      apply_config(16'hFFFF, 127, 127, 1023, 16'hFFFF);
      for (int i = 0; i < NUM_BARS; i++) load_end(i, i + 1);
      send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_bin(32'd1, 32'd1, 1'b1);
      wait_idle();

      // bins after the final bar, and a decreasing table
      apply_config(1, 2, 64, 512, 1);
      load_end(0, 3);
      load_end(1, 2);
      for (int i = 1; i <= 6; i++) send_bin(pick_sample(), pick_sample(), i == 6);
      wait_idle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            case ($urandom_range(0, 7))
               0: n = 0;
               1: n = 60;
               2: n = 64;
               3: n = 127;
               default: n = $urandom_range(1, 8);
            endcase
            apply_config(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) :
                         $urandom_range(0, 5),
                         n,
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) :
                         $urandom_range(1, 64),
                         ($urandom_range(0, 5) == 0) ? 1023 : $urandom_range(0, 1023),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
                         $urandom_range(1, 200));
         end
         nb = (bars_in_frame < 10) ? bars_in_frame : 10;
         n = $urandom_range(1, 24);
         e = 0;
         for (int i = 0; i < nb; i++) begin
            e = e + $urandom_range(0, 4);
            load_end(i, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096) : e);
            sent++;
         end
         for (int i = 1; i <= n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               load_end($urandom_range(0, 63), $urandom_range(0, 4096));
               sent++;
            end
            // leave some frames open so they run into the next one
            send_bin(pick_sample(), pick_sample(), (i == n) && ($urandom_range(0, 7) != 0));
            sent++;
         end
      end

      quiet = 1'b0;
      wait_idle();
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

### sim.f
hw/rtl/sbb_pkg.sv
hw/rtl/sbb_if.sv
hw/rtl/sbb_ctrl.sv
hw/rtl/sbb_datapath.sv
hw/rtl/spectrum_bar_binning_unit.sv
tb/sv/tb.sv
